### hdl/jibe_pkg.sv
package jibe_pkg;

  typedef struct packed {
    logic [7:0] command;
    logic [7:0] imm_hi;
    logic [7:0] imm_lo;
  } in_word_t;

  typedef struct packed {
    logic [15:0]        next_pc;
    logic signed [63:0] top_value;
    logic [4:0]         depth_after;
    logic [2:0]         status;
  } out_word_t;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_DIV_ZERO  = 3'd1;
  localparam logic [2:0] ST_UNSUP     = 3'd2;
  localparam logic [2:0] ST_OVERFLOW  = 3'd3;
  localparam logic [2:0] ST_UNDERFLOW = 3'd4;
  localparam logic [2:0] ST_BAD_LOCAL = 3'd5;

  localparam logic [5:0] INT_SHIFT_MASK  = 6'h1F;
  localparam logic [5:0] LONG_SHIFT_MASK = 6'h3F;

  // ALU operation codes
  typedef enum logic [3:0] {
    ALU_ADD, ALU_SUB, ALU_MUL, ALU_DIV, ALU_REM, ALU_NEG, ALU_SHL, ALU_SHR,
    ALU_USHR, ALU_AND, ALU_OR, ALU_XOR, ALU_PASS
  } alu_op_t;

  typedef struct packed {
    logic    start;
    alu_op_t op;
    logic    lng;
  } alu_ctl_t;

  function automatic logic [63:0] sx32(input logic [63:0] x);
    return {{32{x[31]}}, x[31:0]};
  endfunction

  function automatic logic [63:0] sx16(input logic [63:0] x);
    return {{48{x[15]}}, x[15:0]};
  endfunction

  function automatic logic [63:0] sx8(input logic [63:0] x);
    return {{56{x[7]}}, x[7:0]};
  endfunction

endpackage

### hdl/jibe_ram.sv
module jibe_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### hdl/jibe_alu.sv
module jibe_alu
  import jibe_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  alu_ctl_t    ctl,
  input  logic [63:0] a,
  input  logic [63:0] b,
  output logic        done,
  output logic [63:0] result
);

  typedef enum logic [1:0] {A_IDLE, A_MUL, A_DIV, A_FIX} astate_t;

  astate_t     state_r;
  alu_op_t     op_r;
  logic        lng_r;
  logic [63:0] a_r, b_r;
  logic [63:0] acc_r;
  logic [63:0] rem_r;
  logic [6:0]  cnt_r;
  logic        na_r, nb_r;
  logic        done_r;
  logic [63:0] result_r;

  logic [63:0] ea, eb;
  logic [5:0]  sh;
  logic [63:0] simple;
  logic [64:0] trial;
  logic [63:0] rem_sh;
  logic [63:0] fixed;

  assign ea = ctl.lng ? a : sx32(a);
  assign eb = ctl.lng ? b : sx32(b);
  assign sh = eb[5:0] & (ctl.lng ? LONG_SHIFT_MASK : INT_SHIFT_MASK);

  // combinational operations, result registered at start
  always_comb begin
    unique case (ctl.op)
      ALU_ADD:  simple = ea + eb;
      ALU_SUB:  simple = ea - eb;
      ALU_NEG:  simple = 64'd0 - eb;
      ALU_SHL:  simple = ea << sh;
      ALU_SHR:  simple = $signed(ea) >>> sh;
      ALU_USHR: simple = (ctl.lng ? ea : {32'd0, ea[31:0]}) >> sh;
      ALU_AND:  simple = ea & eb;
      ALU_OR:   simple = ea | eb;
      ALU_XOR:  simple = ea ^ eb;
      default:  simple = eb;
    endcase
  end

  // one restoring divide step
  assign rem_sh = {rem_r[62:0], a_r[63]};
  assign trial  = {1'b0, rem_sh} - {1'b0, b_r};
  assign fixed  = (op_r == ALU_REM) ? (na_r ? 64'd0 - rem_r : rem_r)
                                     : ((na_r != nb_r) ? 64'd0 - acc_r : acc_r);

  // sequence multiply shift-add and divide bit by bit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= A_IDLE;
      done_r  <= 1'b0;
    end else begin
      done_r <= 1'b0;
      unique case (state_r)
        A_IDLE: begin
          if (ctl.start) begin
            op_r  <= ctl.op;
            lng_r <= ctl.lng;
            cnt_r <= 7'd0;
            acc_r <= 64'd0;
            rem_r <= 64'd0;
            na_r  <= ea[63];
            nb_r  <= eb[63];
            if (ctl.op == ALU_MUL) begin
              a_r     <= ea;
              b_r     <= eb;
              state_r <= A_MUL;
            end else if (ctl.op == ALU_DIV || ctl.op == ALU_REM) begin
              a_r     <= ea[63] ? 64'd0 - ea : ea;
              b_r     <= eb[63] ? 64'd0 - eb : eb;
              state_r <= A_DIV;
            end else begin
              result_r <= ctl.lng ? simple : sx32(simple);
              done_r   <= 1'b1;
            end
          end
        end
        A_MUL: begin
          if (b_r[0]) begin
            acc_r <= acc_r + a_r;
          end
          a_r   <= a_r << 1;
          b_r   <= b_r >> 1;
          cnt_r <= cnt_r + 7'd1;
          if (cnt_r == 7'd63) begin
            state_r <= A_FIX;
          end
        end
        A_DIV: begin
          a_r <= a_r << 1;
          if (!trial[64]) begin
            rem_r <= trial[63:0];
            acc_r <= {acc_r[62:0], 1'b1};
          end else begin
            rem_r <= rem_sh;
            acc_r <= {acc_r[62:0], 1'b0};
          end
          cnt_r <= cnt_r + 7'd1;
          if (cnt_r == 7'd63) begin
            state_r <= A_FIX;
          end
        end
        A_FIX: begin
          result_r <= (op_r == ALU_MUL) ? (lng_r ? acc_r : sx32(acc_r))
                                        : (lng_r ? fixed : sx32(fixed));
          done_r   <= 1'b1;
          state_r  <= A_IDLE;
        end
        default: state_r <= A_IDLE;
      endcase
    end
  end

  assign done   = done_r;
  assign result = result_r;

  a_no_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != A_IDLE) |-> !ctl.start) else $error("alu started while busy");
  a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |=> !done_r) else $error("alu done held");
  a_fix_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == A_FIX) |=> done_r) else $error("alu fix without done");

endmodule

### hdl/jvm_integer_bytecode_executor.sv
// Sequence: an accepted simple bytecode passes two stack RAM reads, execute, ALU
// pass, write back and a top-of-stack read before its result is valid; an error
// result skips write back and the top-of-stack read; mul, div and rem wait in the
// shared ALU. Flow: one word at a time; the next word is taken the cycle after the
// result leaves the output register.
// Reset: depth and pc clear at once; a clearing pass then zeroes all
// LOCAL_COUNT locals, during which no word is accepted.
module jvm_integer_bytecode_executor
  import jibe_pkg::*;
#(
  parameter int STACK_DEPTH = 16,
  parameter int LOCAL_COUNT = 64
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_word_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_word_t out_data
);

  localparam int SAW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int SDW = $clog2(STACK_DEPTH + 1);
  localparam int LAW = $clog2(LOCAL_COUNT);

  typedef enum logic [2:0] {S_CLEAR, S_IDLE, S_READ_B, S_READ_A, S_EXEC,
                            S_ALU, S_WRITE, S_OUT} state_t;

  state_t      state_r;
  in_word_t    cmd_r;
  logic [SDW-1:0] depth_r, ndepth_r;
  logic [15:0] pc_r, npc_r;
  logic [63:0] a_r, b_r, loc_r, res_r, top_r;
  logic        push_r, top_rd_r;
  logic [LAW-1:0] clr_r;
  out_word_t   out_r;

  // decode
  logic [7:0] op;
  logic [1:0] npop;
  logic       npush;
  logic [1:0] len;
  logic       has_idx, is_alu, is_store, is_div;
  logic [7:0] lidx;
  logic [2:0] chk;

  assign op = cmd_r.command;

  always_comb begin
    npop = 2'd0; npush = 1'b0; len = 2'd1; has_idx = 1'b0;
    is_alu = 1'b0; is_store = 1'b0; lidx = 8'd0; chk = ST_OK;
    priority if (op == 8'h00) begin
    end else if (op >= 8'h02 && op <= 8'h0a) begin
      npush = 1'b1;
    end else if (op == 8'h10) begin
      npush = 1'b1; len = 2'd2;
    end else if (op == 8'h11) begin
      npush = 1'b1; len = 2'd3;
    end else if (op == 8'h15 || op == 8'h16) begin
      npush = 1'b1; len = 2'd2; has_idx = 1'b1; lidx = cmd_r.imm_hi;
    end else if (op >= 8'h1a && op <= 8'h21) begin
      npush = 1'b1; lidx = {6'd0, op[1:0] - 2'd2};
    end else if (op == 8'h36 || op == 8'h37) begin
      npop = 2'd1; len = 2'd2; has_idx = 1'b1; is_store = 1'b1; lidx = cmd_r.imm_hi;
    end else if (op >= 8'h3b && op <= 8'h42) begin
      npop = 2'd1; is_store = 1'b1; lidx = {6'd0, op[1:0] - 2'd3};
    end else if (op >= 8'h60 && op <= 8'h71 && op[1] == 1'b0) begin
      npop = 2'd2; npush = 1'b1; is_alu = 1'b1;
    end else if (op == 8'h74 || op == 8'h75) begin
      npop = 2'd1; npush = 1'b1; is_alu = 1'b1;
    end else if (op >= 8'h78 && op <= 8'h83) begin
      npop = 2'd2; npush = 1'b1; is_alu = 1'b1;
    end else if (op == 8'h84) begin
      len = 2'd3; has_idx = 1'b1; is_store = 1'b1; lidx = cmd_r.imm_hi;
    end else if (op == 8'h85 || op == 8'h88 || (op >= 8'h91 && op <= 8'h93)) begin
      npop = 2'd1; npush = 1'b1;
    end else if (op == 8'h94) begin
      npop = 2'd2; npush = 1'b1;
    end else if (op >= 8'h99 && op <= 8'h9e) begin
      npop = 2'd1; len = 2'd3;
    end else if (op >= 8'h9f && op <= 8'ha4) begin
      npop = 2'd2; len = 2'd3;
    end else if (op == 8'ha7) begin
      len = 2'd3;
    end else begin
      chk = ST_UNSUP;
    end
  end

  assign is_div = (op >= 8'h6c && op <= 8'h6d) || (op >= 8'h70 && op <= 8'h71);

  // error checks in priority order
  logic [2:0]     status;
  logic [SDW:0]   dep_new;
  always_comb begin
    dep_new = {1'b0, depth_r} - {{(SDW-1){1'b0}}, npop} + {{SDW{1'b0}}, npush};
    status = chk;
    if (status == ST_OK && SDW'(npop) > depth_r) status = ST_UNDERFLOW;
    else if (status == ST_OK && has_idx && {24'd0, lidx} >= LOCAL_COUNT)
      status = ST_BAD_LOCAL;
    else if (status == ST_OK && is_div &&
             (op[0] ? b_r == 64'd0 : b_r[31:0] == 32'd0)) status = ST_DIV_ZERO;
    else if (status == ST_OK && dep_new > (SDW+1)'(STACK_DEPTH)) status = ST_OVERFLOW;
  end

  // non-ALU results and branch decision
  logic [63:0] r_other;
  logic        taken;
  logic [63:0] cb, ca;
  logic        lt, eq;
  logic [3:0]  ck;
  assign cb = (op == 8'h94) ? b_r : ((op <= 8'h9e) ? 64'd0 : sx32(b_r));
  assign ca = (op == 8'h94) ? a_r : ((op <= 8'h9e) ? sx32(b_r) : sx32(a_r));
  assign lt = $signed(ca) < $signed(cb);
  assign eq = ca == cb;
  assign ck = (op <= 8'h9e) ? 4'(op - 8'h99) : 4'(op - 8'h9f);

  always_comb begin
    r_other = 64'd0;
    taken   = 1'b0;
    if (op >= 8'h02 && op <= 8'h08) r_other = 64'(op) - 64'd3;
    else if (op == 8'h09 || op == 8'h0a) r_other = 64'(op) - 64'd9;
    else if (op == 8'h10) r_other = sx8({56'd0, cmd_r.imm_hi});
    else if (op == 8'h11) r_other = sx16({48'd0, cmd_r.imm_hi, cmd_r.imm_lo});
    else if (op >= 8'h1a && op <= 8'h1d) r_other = sx32(loc_r);
    else if (op == 8'h15 || op == 8'h16 || (op >= 8'h1e && op <= 8'h21)) r_other = loc_r;
    else if (op == 8'h85 || op == 8'h88) r_other = sx32(b_r);
    else if (op == 8'h91) r_other = sx8(b_r);
    else if (op == 8'h92) r_other = {48'd0, b_r[15:0]};
    else if (op == 8'h93) r_other = sx16(b_r);
    else if (op == 8'h94) r_other = lt ? '1 : (eq ? 64'd0 : 64'd1);
    else if ((op >= 8'h99 && op <= 8'ha4)) begin
      unique case (ck)
        4'd0:    taken = eq;
        4'd1:    taken = !eq;
        4'd2:    taken = lt;
        4'd3:    taken = !lt;
        4'd4:    taken = !lt && !eq;
        default: taken = lt || eq;
      endcase
    end else if (op == 8'ha7) taken = 1'b1;
  end

  // ALU control
  alu_ctl_t  actl;
  logic      alu_done;
  logic [63:0] alu_res;
  always_comb begin
    unique case ({op[7:1], 1'b0})
      8'h60: actl.op = ALU_ADD;
      8'h64: actl.op = ALU_SUB;
      8'h68: actl.op = ALU_MUL;
      8'h6c: actl.op = ALU_DIV;
      8'h70: actl.op = ALU_REM;
      8'h74: actl.op = ALU_NEG;
      8'h78: actl.op = ALU_SHL;
      8'h7a: actl.op = ALU_SHR;
      8'h7c: actl.op = ALU_USHR;
      8'h7e: actl.op = ALU_AND;
      8'h80: actl.op = ALU_OR;
      8'h82: actl.op = ALU_XOR;
      default: actl.op = ALU_PASS;
    endcase
    actl.lng   = op[0];
    actl.start = (state_r == S_EXEC) && is_alu && (status == ST_OK);
  end

  jibe_alu u_alu (
    .clk(clk), .rst_n(rst_n), .ctl(actl), .a(a_r), .b(b_r),
    .done(alu_done), .result(alu_res)
  );

  // stack RAM
  logic           st_we;
  logic [SAW-1:0] st_waddr, st_raddr;
  logic [63:0]    st_rdata;
  logic [SDW-1:0] st_rsel;

  always_comb begin
    unique case (state_r)
      S_IDLE:   st_rsel = depth_r - SDW'(1);
      S_READ_B: st_rsel = depth_r - SDW'(2);
      default:  st_rsel = ndepth_r - SDW'(1);
    endcase
  end
  assign st_raddr = st_rsel[SAW-1:0];
  assign st_we    = (state_r == S_WRITE) && push_r;
  assign st_waddr = SAW'(ndepth_r - SDW'(1));

  jibe_ram #(.WIDTH(64), .DEPTH(STACK_DEPTH)) u_stack (
    .clk(clk), .we(st_we), .waddr(st_waddr), .wdata(res_r),
    .raddr(st_raddr), .rdata(st_rdata)
  );

  // locals RAM
  logic           lv_we;
  logic [LAW-1:0] lv_waddr;
  logic [63:0]    lv_wdata;
  logic [63:0]    store_val;

  assign store_val = (op == 8'h84) ? sx32(loc_r + sx8({56'd0, cmd_r.imm_lo}))
                   : ((op >= 8'h3b && op <= 8'h3e) ? sx32(b_r) : b_r);
  assign lv_we    = (state_r == S_CLEAR) ||
                    ((state_r == S_EXEC) && is_store && status == ST_OK);
  assign lv_waddr = (state_r == S_CLEAR) ? clr_r : lidx[LAW-1:0];
  assign lv_wdata = (state_r == S_CLEAR) ? 64'd0 : store_val;

  logic [63:0] lv_rdata;
  jibe_ram #(.WIDTH(64), .DEPTH(LOCAL_COUNT)) u_locals (
    .clk(clk), .we(lv_we), .waddr(lv_waddr), .wdata(lv_wdata),
    .raddr(lidx[LAW-1:0]), .rdata(lv_rdata)
  );

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_CLEAR;
      clr_r    <= '0;
      depth_r  <= '0;
      pc_r     <= 16'd0;
      top_r    <= 64'd0;
      top_rd_r <= 1'b0;
    end else begin
      unique case (state_r)
        S_CLEAR: begin
          clr_r <= clr_r + LAW'(1);
          if (clr_r == LAW'(LOCAL_COUNT - 1)) state_r <= S_IDLE;
        end
        S_IDLE: begin
          if (in_valid) begin
            cmd_r   <= in_data;
            state_r <= S_READ_B;
          end
        end
        // top of stack arrives first, the entry below it in the next cycle
        S_READ_B: begin
          b_r     <= st_rdata;
          state_r <= S_READ_A;
        end
        S_READ_A: begin
          a_r     <= st_rdata;
          loc_r   <= lv_rdata;
          state_r <= S_EXEC;
        end
        S_EXEC: begin
          state_r <= S_ALU;
        end
        S_ALU: begin
          // second pass: all operands now held
          if (status != ST_OK) begin
            out_r <= '{next_pc: pc_r, top_value: top_r, depth_after: 5'(depth_r),
                       status: status};
            state_r <= S_OUT;
          end else if (is_alu && !alu_done) begin
          end else begin
            res_r    <= is_alu ? alu_res : r_other;
            push_r   <= npush;
            ndepth_r <= SDW'(dep_new);
            npc_r    <= taken ? pc_r + {cmd_r.imm_hi, cmd_r.imm_lo}
                              : pc_r + {14'd0, len};
            state_r  <= S_WRITE;
          end
        end
        S_WRITE: begin
          depth_r  <= ndepth_r;
          pc_r     <= npc_r;
          top_rd_r <= 1'b1;
          state_r  <= S_OUT;
          out_r    <= '{next_pc: npc_r, top_value: 64'd0, depth_after: 5'(ndepth_r),
                        status: ST_OK};
        end
        S_OUT: begin
          if (top_rd_r) begin
            top_rd_r <= 1'b0;
            out_r.top_value <= (depth_r == '0) ? 64'd0 : (push_r ? res_r : st_rdata);
            top_r <= (depth_r == '0) ? 64'd0 : (push_r ? res_r : st_rdata);
          end else if (out_ready) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = (state_r == S_OUT) && !top_rd_r;
  assign out_data  = out_r;

  a_depth_range: assert property (@(posedge clk) disable iff (!rst_n)
    depth_r <= SDW'(STACK_DEPTH)) else $error("stack depth out of range");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready) else $error("accept while result pending");
  a_pc_hold_err: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.status != ST_OK) |-> out_data.next_pc == pc_r)
    else $error("pc moved on error");

endmodule
